// ===== src/apbl_pkg.sv =====
package apbl_pkg;

    // Field widths of the request and response
    localparam int AZIMUTH_BITS      = 16;
    localparam int ELEVATION_BITS    = 16;
    localparam int ENTRY_BITS        = 20;
    localparam int ROW_INDEX_BITS    = 7;
    localparam int COLUMN_INDEX_BITS = 5;
    localparam int VARIATION_BITS    = 20;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 20;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_AZIMUTH_ROWS          = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ZENITH_COLUMNS        = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ZENITH_STEPS_PER_TURN = 2'd2;

    localparam int ROWS_REG_BITS  = 8;
    localparam int COLS_REG_BITS  = 6;
    localparam int STEPS_REG_BITS = 20;

    localparam logic [ROWS_REG_BITS-1:0]  ROWS_RESET  = 8'd72;
    localparam logic [COLS_REG_BITS-1:0]  COLS_RESET  = 6'd19;
    localparam logic [STEPS_REG_BITS-1:0] STEPS_RESET = 20'd18432;

    // Request kinds
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Zenith = quarter turn - elevation, Q16 turns
    localparam logic signed [ELEVATION_BITS+1:0] QUARTER_TURN = 18'sd16384;

    // Zenith product: Q16 angle times Q8 steps per turn
    localparam int ZENITH_PROD_BITS  = 36;
    localparam int ZENITH_INDEX_BITS = ZENITH_PROD_BITS - 24;

    // Output saturation limits
    localparam logic signed [VARIATION_BITS-1:0] VARIATION_MAX = 20'sh7FFFF;
    localparam logic signed [VARIATION_BITS-1:0] VARIATION_MIN = 20'sh80000;

    typedef struct packed {
        logic                                mode;
        logic [ROW_INDEX_BITS-1:0]           row_index;
        logic [COLUMN_INDEX_BITS-1:0]        column_index;
        logic signed [ENTRY_BITS-1:0]        entry_value;
        logic [AZIMUTH_BITS-1:0]             azimuth;
        logic signed [ELEVATION_BITS-1:0]    elevation;
    } request_t;

    typedef struct packed {
        logic signed [VARIATION_BITS-1:0]    variation;
        logic                                is_query_result;
    } result_t;

endpackage

// ===== src/apbl_grid_mem.sv =====
module apbl_grid_mem #(
    parameter int DEPTH     = 4096,
    parameter int DATA_BITS = 20,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_BITS-1:0]        wr_addr,
    input  logic signed [DATA_BITS-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_BITS-1:0]        rd_addr_a,
    input  logic [ADDR_BITS-1:0]        rd_addr_b,
    output logic signed [DATA_BITS-1:0] rd_data_a,
    output logic signed [DATA_BITS-1:0] rd_data_b
);

    logic signed [DATA_BITS-1:0] store_reg [DEPTH];
    logic signed [DATA_BITS-1:0] rd_data_a_reg;
    logic signed [DATA_BITS-1:0] rd_data_b_reg;

    // One write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports; data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a_reg <= store_reg[rd_addr_a];
            rd_data_b_reg <= store_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ===== src/antenna_pattern_bilinear_lookup.sv =====
// Bilinear lookup in a phase-center-variation grid (rows = azimuth, wrapped;
// columns = zenith, clamped). A write request (mode 0) stores one entry and
// returns an acknowledge with variation 0; a query request (mode 1) returns
// the interpolated variation, rounded to nearest and saturated to 20 bits.
// One request is accepted every cycle while the output is not stalled; each
// response passes through the registered stages A to F. The four neighboring
// entries are fetched together from two copies of the grid memory, each read
// at two addresses, and every write updates both copies. A write is visible
// to every query accepted after it. Reading an entry that was never written
// returns an unspecified value. Configuration must be written by the user
// only while no request is in flight; the block itself does not enforce it.
module antenna_pattern_bilinear_lookup #(
    parameter int MAX_ROWS    = 128,
    parameter int MAX_COLUMNS = 32,
    parameter int VALUE_BITS  = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [apbl_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [apbl_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  apbl_pkg::request_t                   req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output apbl_pkg::result_t                    rsp
);

    import apbl_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int RIW   = $clog2(MAX_ROWS);
    localparam int CIW   = $clog2(MAX_COLUMNS);
    localparam int PAW   = AZIMUTH_BITS + RCW;
    localparam int ZPW   = ZENITH_PROD_BITS;
    localparam int ZIW   = ZENITH_INDEX_BITS;
    localparam int PW    = VALUE_BITS + 18;
    localparam int TW    = VALUE_BITS + 17;
    localparam int DW    = TW + 1;
    localparam int HW    = DW - 16;
    localparam int SW    = VALUE_BITS + 36;

    localparam logic signed [32:0] VMAX = (33'sd1 <<< (VALUE_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] VMIN = -VMAX - 33'sd1;
    localparam logic signed [SW-1:0] ROUND_HALF = SW'(33'sd2147483648);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ROWS_REG_BITS-1:0]  rows_reg;
    logic [COLS_REG_BITS-1:0]  cols_reg;
    logic [STEPS_REG_BITS-1:0] steps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= ROWS_RESET;
            cols_reg  <= COLS_RESET;
            steps_reg <= STEPS_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_AZIMUTH_ROWS:          rows_reg  <= cfg_data[ROWS_REG_BITS-1:0];
                CFG_ZENITH_COLUMNS:        cols_reg  <= cfg_data[COLS_REG_BITS-1:0];
                CFG_ZENITH_STEPS_PER_TURN: steps_reg <= cfg_data[STEPS_REG_BITS-1:0];
                default:                   ;
            endcase
        end
    end

    // Row count clamped to 1..MAX_ROWS, last column clamped to 0..MAX_COLUMNS-1
    logic [RCW-1:0] rows_eff;
    logic [CIW-1:0] cols_last;

    always_comb
    begin
        if (rows_reg == '0)
        begin
            rows_eff = RCW'(1);
        end
        else if (int'(rows_reg) > MAX_ROWS)
        begin
            rows_eff = RCW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = RCW'(rows_reg);
        end

        if (cols_reg == '0)
        begin
            cols_last = '0;
        end
        else if (int'(cols_reg) > MAX_COLUMNS)
        begin
            cols_last = CIW'(MAX_COLUMNS - 1);
        end
        else
        begin
            cols_last = CIW'(cols_reg - 6'd1);
        end
    end

    function automatic logic [AW-1:0] grid_addr(input logic [RIW-1:0] r,
                                                input logic [CIW-1:0] c);
        return AW'(int'(r) * MAX_COLUMNS + int'(c));
    endfunction

    // ------------------------------------------------------------------
    // Pipeline handshake: a stage loads when empty or when it moves on
    // ------------------------------------------------------------------
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg, f_valid_reg;
    logic a_ready, b_ready, c_ready, d_ready, e_ready, f_ready;

    assign f_ready   = !f_valid_reg || rsp_ready;
    assign e_ready   = !e_valid_reg || f_ready;
    assign d_ready   = !d_valid_reg || e_ready;
    assign c_ready   = !c_valid_reg || d_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign req_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready) a_valid_reg <= req_valid;
            if (b_ready) b_valid_reg <= a_valid_reg;
            if (c_ready) c_valid_reg <= b_valid_reg;
            if (d_ready) d_valid_reg <= c_valid_reg;
            if (e_ready) e_valid_reg <= d_valid_reg;
            if (f_ready) f_valid_reg <= e_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: scale azimuth and zenith; prepare a grid write
    // ------------------------------------------------------------------
    logic signed [ELEVATION_BITS+1:0] zenith;
    logic [PAW-1:0]                   pa_next;
    logic [ZPW-1:0]                   pz_next;
    logic signed [32:0]               entry_ext;
    logic signed [VALUE_BITS-1:0]     entry_next;
    logic                             wr_ok_next;
    logic [AW-1:0]                    wr_addr_next;

    always_comb
    begin
        pa_next = PAW'(req.azimuth) * PAW'(rows_eff);

        // Negative zenith clamps to column 0 with zero weight
        zenith = QUARTER_TURN - 18'(req.elevation);
        if (zenith > 18'sd0)
        begin
            pz_next = ZPW'(zenith[AZIMUTH_BITS-1:0]) * ZPW'(steps_reg);
        end
        else
        begin
            pz_next = '0;
        end

        // Entry saturated to the store width
        entry_ext = 33'(req.entry_value);
        if (entry_ext > VMAX)
        begin
            entry_next = VALUE_BITS'(VMAX);
        end
        else if (entry_ext < VMIN)
        begin
            entry_next = VALUE_BITS'(VMIN);
        end
        else
        begin
            entry_next = VALUE_BITS'(entry_ext);
        end

        wr_ok_next   = (req.mode == MODE_WRITE) && (int'(req.row_index) < MAX_ROWS)
                       && (int'(req.column_index) < MAX_COLUMNS);
        wr_addr_next = AW'(int'(req.row_index) * MAX_COLUMNS + int'(req.column_index));
    end

    logic                         a_mode_reg;
    logic [PAW-1:0]               a_pa_reg;
    logic [ZPW-1:0]               a_pz_reg;
    logic                         a_wr_ok_reg;
    logic [AW-1:0]                a_wr_addr_reg;
    logic signed [VALUE_BITS-1:0] a_entry_reg;

    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_mode_reg    <= req.mode;
            a_pa_reg      <= pa_next;
            a_pz_reg      <= pz_next;
            a_wr_ok_reg   <= wr_ok_next;
            a_wr_addr_reg <= wr_addr_next;
            a_entry_reg   <= entry_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: neighbor indices, grid write and four grid reads
    // ------------------------------------------------------------------
    logic [RCW-1:0] a1_full;
    logic [RCW:0]   a1_inc;
    logic [RIW-1:0] row1, row2;
    logic [ZIW-1:0] zi;
    logic [CIW-1:0] col1, col2;
    logic [AW-1:0]  addr11, addr12, addr21, addr22;
    logic           grid_wr_en, grid_rd_en;

    always_comb
    begin
        a1_full = a_pa_reg[PAW-1:AZIMUTH_BITS];
        a1_inc  = (RCW+1)'(a1_full) + (RCW+1)'(1);
        row1    = RIW'(a1_full);
        // Azimuth wraps past the last row in use
        if (a1_inc >= (RCW+1)'(rows_eff))
        begin
            row2 = '0;
        end
        else
        begin
            row2 = RIW'(a1_inc);
        end

        // Zenith clamps to the last column in use
        zi = a_pz_reg[ZPW-1:24];
        if (zi > ZIW'(cols_last))
        begin
            col1 = cols_last;
        end
        else
        begin
            col1 = CIW'(zi);
        end
        if (col1 == cols_last)
        begin
            col2 = cols_last;
        end
        else
        begin
            col2 = col1 + CIW'(1);
        end

        addr11 = grid_addr(row1, col1);
        addr12 = grid_addr(row1, col2);
        addr21 = grid_addr(row2, col1);
        addr22 = grid_addr(row2, col2);
    end

    assign grid_wr_en = b_ready && a_valid_reg && (a_mode_reg == MODE_WRITE) && a_wr_ok_reg;
    assign grid_rd_en = b_ready && a_valid_reg && (a_mode_reg == MODE_QUERY);

    logic signed [VALUE_BITS-1:0] e11, e12, e21, e22;

    // Copy read at the first azimuth row of the pair
    apbl_grid_mem #(
        .DEPTH     (DEPTH),
        .DATA_BITS (VALUE_BITS),
        .ADDR_BITS (AW)
    ) u_grid_row1 (
        .clk       (clk),
        .wr_en     (grid_wr_en),
        .wr_addr   (a_wr_addr_reg),
        .wr_data   (a_entry_reg),
        .rd_en     (grid_rd_en),
        .rd_addr_a (addr11),
        .rd_addr_b (addr12),
        .rd_data_a (e11),
        .rd_data_b (e12)
    );

    // Copy read at the second azimuth row of the pair
    apbl_grid_mem #(
        .DEPTH     (DEPTH),
        .DATA_BITS (VALUE_BITS),
        .ADDR_BITS (AW)
    ) u_grid_row2 (
        .clk       (clk),
        .wr_en     (grid_wr_en),
        .wr_addr   (a_wr_addr_reg),
        .wr_data   (a_entry_reg),
        .rd_en     (grid_rd_en),
        .rd_addr_a (addr21),
        .rd_addr_b (addr22),
        .rd_data_a (e21),
        .rd_data_b (e22)
    );

    logic                    b_mode_reg;
    logic [AZIMUTH_BITS-1:0] b_fa_reg;
    logic [AZIMUTH_BITS-1:0] b_fz_reg;

    always_ff @(posedge clk)
    begin
        if (b_ready)
        begin
            b_mode_reg <= a_mode_reg;
            b_fa_reg   <= a_pa_reg[AZIMUTH_BITS-1:0];
            b_fz_reg   <= a_pz_reg[23:8];
        end
    end

    // ------------------------------------------------------------------
    // Stage C: interpolate along zenith, t = e1 * 2^16 + fz * (e2 - e1)
    // ------------------------------------------------------------------
    logic signed [VALUE_BITS:0] dz1, dz2;
    logic signed [PW-1:0]       e11_w, e21_w, prod_z1, prod_z2;
    logic signed [TW-1:0]       t1_next, t2_next;

    always_comb
    begin
        dz1     = (VALUE_BITS+1)'(e12) - (VALUE_BITS+1)'(e11);
        dz2     = (VALUE_BITS+1)'(e22) - (VALUE_BITS+1)'(e21);
        prod_z1 = $signed({1'b0, b_fz_reg}) * dz1;
        prod_z2 = $signed({1'b0, b_fz_reg}) * dz2;
        e11_w   = PW'(e11);
        e21_w   = PW'(e21);
        t1_next = TW'((e11_w <<< 16) + prod_z1);
        t2_next = TW'((e21_w <<< 16) + prod_z2);
    end

    logic                    c_mode_reg;
    logic [AZIMUTH_BITS-1:0] c_fa_reg;
    logic signed [TW-1:0]    c_t1_reg, c_t2_reg;

    always_ff @(posedge clk)
    begin
        if (c_ready)
        begin
            c_mode_reg <= b_mode_reg;
            c_fa_reg   <= b_fa_reg;
            c_t1_reg   <= t1_next;
            c_t2_reg   <= t2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: azimuth difference of the two zenith results
    // ------------------------------------------------------------------
    logic signed [DW-1:0] diff_next;

    assign diff_next = DW'(c_t2_reg) - DW'(c_t1_reg);

    logic                    d_mode_reg;
    logic [AZIMUTH_BITS-1:0] d_fa_reg;
    logic signed [TW-1:0]    d_t1_reg;
    logic signed [DW-1:0]    d_diff_reg;

    always_ff @(posedge clk)
    begin
        if (d_ready)
        begin
            d_mode_reg <= c_mode_reg;
            d_fa_reg   <= c_fa_reg;
            d_t1_reg   <= c_t1_reg;
            d_diff_reg <= diff_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: fa * diff as high and low partial products
    // ------------------------------------------------------------------
    logic signed [HW+16:0] ph_next;
    logic [31:0]           pl_next;

    always_comb
    begin
        ph_next = $signed({1'b0, d_fa_reg}) * $signed(d_diff_reg[DW-1:16]);
        pl_next = 32'(d_fa_reg) * 32'(d_diff_reg[15:0]);
    end

    logic                  e_mode_reg;
    logic signed [TW-1:0]  e_t1_reg;
    logic signed [HW+16:0] e_ph_reg;
    logic [31:0]           e_pl_reg;

    always_ff @(posedge clk)
    begin
        if (e_ready)
        begin
            e_mode_reg <= d_mode_reg;
            e_t1_reg   <= d_t1_reg;
            e_ph_reg   <= ph_next;
            e_pl_reg   <= pl_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage F: sum, round to nearest, saturate
    // ------------------------------------------------------------------
    logic signed [SW-1:0]             t1_w, ph_w, pl_w, sum_w, res_w;
    logic signed [VARIATION_BITS-1:0] var_sat;
    result_t                          rsp_next;

    always_comb
    begin
        t1_w  = SW'(e_t1_reg);
        ph_w  = SW'(e_ph_reg);
        pl_w  = SW'($signed({1'b0, e_pl_reg}));
        sum_w = ((t1_w + ph_w) <<< 16) + pl_w + ROUND_HALF;
        res_w = sum_w >>> 32;

        if (res_w > SW'(VARIATION_MAX))
        begin
            var_sat = VARIATION_MAX;
        end
        else if (res_w < SW'(VARIATION_MIN))
        begin
            var_sat = VARIATION_MIN;
        end
        else
        begin
            var_sat = VARIATION_BITS'(res_w);
        end

        // Write acknowledge carries zero
        rsp_next.is_query_result = (e_mode_reg == MODE_QUERY);
        rsp_next.variation       = (e_mode_reg == MODE_QUERY) ? var_sat : '0;
    end

    result_t rsp_reg;

    always_ff @(posedge clk)
    begin
        if (f_ready)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = f_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    ack_zero_a: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.is_query_result |-> rsp.variation == '0)
        else $error("write acknowledge with nonzero variation");

    read_hold_a: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !c_ready |=> $stable(e11) && $stable(e12) && $stable(e21)
                                    && $stable(e22))
        else $error("grid read data changed while stage B stalled");

    addr_range_a: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && (a_mode_reg == MODE_QUERY) |->
            int'(addr11) < DEPTH && int'(addr12) < DEPTH
            && int'(addr21) < DEPTH && int'(addr22) < DEPTH)
        else $error("grid read address beyond the grid");

endmodule
